FILE: sv/fifd_pkg.sv
// Shared types, constants and the helper function of the FAST integer field decoder.
`timescale 1ns / 1ps

package fifd_pkg;

    // Dictionary size and the address width that follows from it.
    localparam int DICT_ENTRIES = 64;
    localparam int DICT_AW      = $clog2(DICT_ENTRIES);

    // Byte limits for a field without a stop bit.
    localparam int MAX_BYTES_WIDE   = 10;
    localparam int MAX_BYTES_NARROW = 5;

    // Stream byte layout.
    localparam int STOP_POS      = 7;
    localparam int SIGN_POS      = 6;
    localparam int BITS_PER_BYTE = 7;

    // Field widths.
    localparam int VALUE_W = 64;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 4;

    // Input and output word widths on the stream ports.
    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 72;

    // What the word on the input side carries.
    typedef enum logic [1:0] {
        ACT_DATA   = 2'd0,
        ACT_ABSENT = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

    // Field operators.
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_CONST = 3'd1,
        OP_DFLT  = 3'd2,
        OP_COPY  = 3'd3,
        OP_INCR  = 3'd4,
        OP_DIFF  = 3'd5
    } op_t;

    // One input word, held in the input register.
    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         data_byte;
        logic [SLOT_W-1:0]  field_slot;
        logic [2:0]         field_op;
        logic               pmap_bit;
        logic               is_signed;
        logic               is_wide;
        logic               is_optional;
        logic [VALUE_W-1:0] init_value;
        logic               init_present;
    } item_t;

    // Trim a value to its field width: 32-bit fields are sign- or zero-extended.
    function automatic logic [VALUE_W-1:0] fit_value(input logic [VALUE_W-1:0] v,
                                                     input logic wide,
                                                     input logic sgn);
        logic [VALUE_W-1:0] r;
        if (wide)
        begin
            r = v;
        end
        else
        begin
            r = {{(VALUE_W/2){sgn & v[VALUE_W/2-1]}}, v[VALUE_W/2-1:0]};
        end
        return r;
    endfunction

endpackage

FILE: sv/fifd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module fifd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/fast_integer_field_decoder_unit.sv
// Top level of the FAST stop-bit integer field decoder with its operator dictionary.
`timescale 1ns / 1ps

// The block takes one word per clock and hands back at most one decoded field per word.
// An accepted word is held in the input register, and its result is registered in the
// result register, which drives the output. A field takes as many words as it has bytes,
// one per cycle while the input side does not stall; an absent field is a single word.
// Sustained rate is one word per cycle while the output side keeps up: the dictionary
// RAM is read when a word is accepted and written when that word leaves the input
// register, and a read that meets the write of the word just ahead is served from a
// forwarding register. Dictionary entries are valid only once written; valid bits live
// in flip-flops, so a clear-dictionary word takes effect at once. The input side stalls
// only while a finished result waits on the output side and the word in the input
// register cannot move on.
module fast_integer_field_decoder_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input: data_byte[7:0], field_slot[13:8], field_op[16:14], pmap_bit[17],
    // is_signed[18], is_wide[19], is_optional[20], init_value[84:21],
    // init_present[85], zero padding [87:86].
    input  logic [fifd_pkg::IN_DATA_W-1:0]  s_tdata,
    // Input: action[1:0].
    input  logic [fifd_pkg::IN_USER_W-1:0]  s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Output: value[63:0], is_null[64], overlong[65], slot_out[71:66].
    output logic [fifd_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready
);

    import fifd_pkg::*;

    // Input register stage.
    item_t              s1_reg;
    item_t              s1_next;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s_accept;
    logic               s1_go;
    logic               out_free;

    // Partial field state.
    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] acc_next;
    logic [COUNT_W-1:0] bytes_reg;
    logic [COUNT_W-1:0] bytes_next;

    // Dictionary.
    logic [DICT_ENTRIES-1:0] valid_reg;
    logic [DICT_ENTRIES-1:0] valid_next;
    logic [DICT_AW-1:0]      in_idx;
    logic [DICT_AW-1:0]      s1_idx;
    logic [VALUE_W-1:0]      ram_rdata;
    logic                    fwd_hit_reg;
    logic                    fwd_hit_next;
    logic [VALUE_W-1:0]      fwd_data_reg;
    logic                    wr_en;
    logic [VALUE_W-1:0]      wr_data;
    logic                    clr_dict;

    // Result register.
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [VALUE_W-1:0] m_value_reg;
    logic               m_null_reg;
    logic               m_ovl_reg;
    logic [SLOT_W-1:0]  m_slot_reg;

    // Decode and operator logic.
    logic [VALUE_W-1:0] acc_start;
    logic [VALUE_W-1:0] acc_base;
    logic [VALUE_W-1:0] acc_shift;
    logic [COUNT_W-1:0] bytes_inc;
    logic [COUNT_W-1:0] byte_limit;
    logic [VALUE_W-1:0] dval_raw;
    logic [VALUE_W-1:0] dval;
    logic               dnull;
    logic               dec;
    logic [VALUE_W-1:0] init_fit;
    logic               prev_valid;
    logic [VALUE_W-1:0] prev_value;
    logic               has_base;
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] base_inc;
    logic [VALUE_W-1:0] base_sum;
    logic               present;
    logic               do_op;
    logic               res_valid;
    logic [VALUE_W-1:0] res_value;
    logic               res_null;
    logic               res_ovl;

    // Handshake between the stages.
    assign out_free = !m_valid_reg || m_tready;
    assign s1_go    = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    // Unpack the incoming word.
    always_comb
    begin
        s1_next.action       = s_tuser;
        s1_next.data_byte    = s_tdata[7:0];
        s1_next.field_slot   = s_tdata[13:8];
        s1_next.field_op     = s_tdata[16:14];
        s1_next.pmap_bit     = s_tdata[17];
        s1_next.is_signed    = s_tdata[18];
        s1_next.is_wide      = s_tdata[19];
        s1_next.is_optional  = s_tdata[20];
        s1_next.init_value   = s_tdata[84:21];
        s1_next.init_present = s_tdata[85];
    end

    assign in_idx = s1_next.field_slot[DICT_AW-1:0];
    assign s1_idx = s1_reg.field_slot[DICT_AW-1:0];

    assign s1_valid_next = s_accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
    // A read issued in the same cycle as a write to the same entry sees old RAM data.
    assign fwd_hit_next  = wr_en && (in_idx == s1_idx);

    // Dictionary value storage.
    fifd_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DICT_ENTRIES)
    ) u_dict (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_idx),
        .wr_data (wr_data),
        .rd_en   (s_accept),
        .rd_addr (in_idx),
        .rd_data (ram_rdata)
    );

    // Accumulate the 7 payload bits of the current byte.
    always_comb
    begin
        acc_start  = (s1_reg.is_signed && s1_reg.data_byte[SIGN_POS]) ? '1 : '0;
        acc_base   = (bytes_reg == '0) ? acc_start : acc_reg;
        acc_shift  = {acc_base[VALUE_W-BITS_PER_BYTE-1:0],
                      s1_reg.data_byte[BITS_PER_BYTE-1:0]};
        bytes_inc  = (bytes_reg == '1) ? bytes_reg : bytes_reg + COUNT_W'(1);
        byte_limit = s1_reg.is_wide ? COUNT_W'(MAX_BYTES_WIDE) : COUNT_W'(MAX_BYTES_NARROW);
    end

    // Null and decrement rule for optional fields.
    always_comb
    begin
        dval_raw = fit_value(acc_shift, s1_reg.is_wide, s1_reg.is_signed);
        dnull    = s1_reg.is_optional && (dval_raw == '0);
        dec      = s1_reg.is_optional && (dval_raw != '0)
                   && !(s1_reg.is_signed && dval_raw[VALUE_W-1]);
        dval     = fit_value(dval_raw - VALUE_W'(dec), s1_reg.is_wide, s1_reg.is_signed);
    end

    // Base value for copy, increment and delta.
    always_comb
    begin
        init_fit   = fit_value(s1_reg.init_value, s1_reg.is_wide, s1_reg.is_signed);
        prev_valid = valid_reg[s1_idx];
        prev_value = fwd_hit_reg ? fwd_data_reg : ram_rdata;
        has_base   = prev_valid || s1_reg.init_present;
        base       = prev_valid ? prev_value : init_fit;
        base_inc   = fit_value(base + VALUE_W'(1), s1_reg.is_wide, s1_reg.is_signed);
        // The decrement folds into the delta sum; the field trim makes the two equal.
        base_sum   = fit_value(base + dval_raw + {VALUE_W{dec}},
                               s1_reg.is_wide, s1_reg.is_signed);
    end

    // Action handling and the partial field state.
    always_comb
    begin
        acc_next   = acc_reg;
        bytes_next = bytes_reg;
        present    = 1'b0;
        do_op      = 1'b0;
        clr_dict   = 1'b0;
        res_ovl    = 1'b0;
        case (action_t'(s1_reg.action))
            ACT_DATA:
            begin
                if (s1_reg.data_byte[STOP_POS])
                begin
                    acc_next   = '0;
                    bytes_next = '0;
                    present    = 1'b1;
                    do_op      = 1'b1;
                end
                else if (bytes_inc >= byte_limit)
                begin
                    acc_next   = '0;
                    bytes_next = '0;
                    res_ovl    = 1'b1;
                end
                else
                begin
                    acc_next   = acc_shift;
                    bytes_next = bytes_inc;
                end
            end
            ACT_ABSENT:
            begin
                acc_next   = '0;
                bytes_next = '0;
                do_op      = 1'b1;
            end
            ACT_CLEAR:
            begin
                acc_next   = '0;
                bytes_next = '0;
                clr_dict   = 1'b1;
            end
            default:
            begin
                acc_next   = acc_reg;
                bytes_next = bytes_reg;
            end
        endcase
    end

    // Field operators: result word and dictionary update.
    always_comb
    begin
        res_valid = do_op || res_ovl;
        res_value = '0;
        res_null  = 1'b0;
        wr_en     = 1'b0;
        wr_data   = dval;
        if (do_op)
        begin
            case (op_t'(s1_reg.field_op))
                OP_CONST:
                begin
                    if ((s1_reg.pmap_bit || present) && s1_reg.init_present)
                    begin
                        res_value = init_fit;
                    end
                    else
                    begin
                        res_null = 1'b1;
                    end
                end
                OP_DFLT:
                begin
                    if (present)
                    begin
                        res_value = dval;
                        res_null  = dnull;
                    end
                    else
                    begin
                        res_value = init_fit;
                        res_null  = !s1_reg.init_present;
                    end
                end
                OP_COPY, OP_INCR:
                begin
                    if (present)
                    begin
                        res_value = dval;
                        res_null  = dnull;
                        wr_en     = !dnull;
                    end
                    else if (!has_base)
                    begin
                        res_null = 1'b1;
                    end
                    else if (op_t'(s1_reg.field_op) == OP_INCR)
                    begin
                        res_value = base_inc;
                        wr_en     = 1'b1;
                        wr_data   = base_inc;
                    end
                    else
                    begin
                        res_value = base;
                    end
                end
                OP_DIFF:
                begin
                    if (!present)
                    begin
                        res_null = 1'b1;
                    end
                    else if (has_base && dnull)
                    begin
                        res_value = base;
                    end
                    else if (has_base)
                    begin
                        res_value = base_sum;
                        wr_en     = 1'b1;
                        wr_data   = base_sum;
                    end
                    else if (dnull)
                    begin
                        res_null = 1'b1;
                    end
                    else
                    begin
                        res_value = dval;
                        wr_en     = 1'b1;
                    end
                end
                default:
                begin
                    if (present)
                    begin
                        res_value = dval;
                        res_null  = dnull;
                    end
                    else
                    begin
                        res_null = 1'b1;
                    end
                end
            endcase
            if (res_null)
            begin
                res_value = '0;
            end
            wr_en = wr_en && s1_go;
        end
    end

    // Valid bits of the dictionary entries.
    always_comb
    begin
        valid_next = valid_reg;
        if (s1_go && clr_dict)
        begin
            valid_next = '0;
        end
        else if (wr_en)
        begin
            valid_next[s1_idx] = 1'b1;
        end
    end

    assign m_valid_next = (s1_go && res_valid) ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            acc_reg      <= '0;
            bytes_reg    <= '0;
            valid_reg    <= '0;
            fwd_hit_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            valid_reg    <= valid_next;
            if (s1_go)
            begin
                acc_reg   <= acc_next;
                bytes_reg <= bytes_next;
            end
            if (s_accept)
            begin
                fwd_hit_reg <= fwd_hit_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_reg       <= s1_next;
            fwd_data_reg <= wr_data;
        end
        if (s1_go && res_valid)
        begin
            m_value_reg <= res_value;
            m_null_reg  <= res_null;
            m_ovl_reg   <= res_ovl;
            m_slot_reg  <= s1_reg.field_slot;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_slot_reg, m_ovl_reg, m_null_reg, m_value_reg};

    // A clear-dictionary word leaves no entry valid.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && (s1_reg.action == ACT_CLEAR)) |=> (valid_reg == '0))
        else $error("dictionary not empty after clear");

    // Null and overlong results carry a zero value.
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (m_null_reg || m_ovl_reg)) |-> (m_value_reg == '0))
        else $error("null or overlong result with nonzero value");

    // An overlong result is never marked null.
    a_ovl_not_null: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_ovl_reg) |-> !m_null_reg)
        else $error("overlong result marked null");

    // A read that meets a write to the same entry is forwarded.
    a_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && wr_en && (in_idx == s1_idx)) |=> fwd_hit_reg)
        else $error("read-during-write not forwarded");

endmodule

FILE: dv/fifd_stream_checker.sv
// Stream checker for the FAST integer field decoder: predicts each decoded field and compares it.
`timescale 1ns / 1ps

module fifd_stream_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [fifd_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [fifd_pkg::IN_USER_W-1:0]  s_tuser,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [fifd_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    output int                              error_count,
    output int                              pending,
    output int                              checked_count
);

    import fifd_pkg::*;

    // Output word layout, highest field first as a packed struct lays it out.
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               overlong;
        logic               is_null;
        logic [VALUE_W-1:0] value;
    } field_word_t;

    // Partial field being gathered, and the per-slot dictionary.
    logic [VALUE_W-1:0] field_acc;
    logic [COUNT_W-1:0] field_bytes;
    logic               field_negative;
    logic [VALUE_W-1:0] dict_value [DICT_ENTRIES];
    logic               dict_valid [DICT_ENTRIES];

    field_word_t expected_fields [$];
    int          mismatch_count;

    // A 32-bit field keeps its low half, extended by its sign when signed.
    function automatic logic [VALUE_W-1:0] width_trim(input logic [VALUE_W-1:0] v,
                                                      input logic wide,
                                                      input logic sgn);
        if (wide)
        begin
            return v;
        end
        return {{32{sgn & v[31]}}, v[31:0]};
    endfunction

    // Build an output word; the value reads as zero when null or overlong.
    function automatic field_word_t field_word(input logic [VALUE_W-1:0] v,
                                              input logic nul,
                                              input logic ovl,
                                              input logic [SLOT_W-1:0] slot);
        field_word_t w;
        w.value    = (nul || ovl) ? '0 : v;
        w.is_null  = nul;
        w.overlong = ovl;
        w.slot     = slot;
        return w;
    endfunction

    // Work out what one accepted input word does and queue any decoded field it yields.
    task automatic decode_word(input logic [IN_USER_W-1:0] act,
                               input logic [IN_DATA_W-1:0] d);
        logic [7:0]         byte_in;
        logic [SLOT_W-1:0]  slot;
        logic [2:0]         op;
        logic               pbit;
        logic               sgn;
        logic               wide;
        logic               opt;
        logic               ip;
        logic [VALUE_W-1:0] init;
        logic [VALUE_W-1:0] dval;
        logic [VALUE_W-1:0] base;
        logic               dnull;
        logic               present;
        logic               has_base;
        int                 limit;
        field_word_t        r;

        byte_in = d[7:0];
        slot    = d[13:8];
        op      = d[16:14];
        pbit    = d[17];
        sgn     = d[18];
        wide    = d[19];
        opt     = d[20];
        init    = width_trim(d[84:21], d[19], d[18]);
        ip      = d[85];
        dval    = '0;
        dnull   = 1'b0;
        present = 1'b0;

        // Clearing drops the partial field and every dictionary entry; spare codes do nothing.
        if (act == ACT_CLEAR)
        begin
            field_acc      = '0;
            field_bytes    = '0;
            field_negative = 1'b0;
            for (int i = 0; i < DICT_ENTRIES; i++)
            begin
                dict_valid[i] = 1'b0;
            end
            return;
        end
        if (act != ACT_DATA && act != ACT_ABSENT)
        begin
            return;
        end
        if (op > OP_DIFF)
        begin
            op = OP_NONE;
        end

        if (act == ACT_DATA)
        begin
            // The sign comes from bit 6 of the first byte of a signed field.
            if (field_bytes == 0)
            begin
                field_negative = sgn & byte_in[SIGN_POS];
                field_acc      = field_negative ? '1 : '0;
            end
            field_acc = (field_acc << BITS_PER_BYTE) | VALUE_W'(byte_in[6:0]);
            if (field_bytes < 15)
            begin
                field_bytes = field_bytes + 1'b1;
            end
            if (!byte_in[STOP_POS])
            begin
                limit = wide ? MAX_BYTES_WIDE : MAX_BYTES_NARROW;
                if (int'(field_bytes) >= limit)
                begin
                    field_acc      = '0;
                    field_bytes    = '0;
                    field_negative = 1'b0;
                    expected_fields.push_back(field_word('0, 1'b0, 1'b1, slot));
                end
                return;
            end
            dval           = width_trim(field_acc, wide, sgn);
            field_acc      = '0;
            field_bytes    = '0;
            field_negative = 1'b0;
            // Nullable fields: zero is null, other non-negative values are one too high.
            if (opt)
            begin
                if (dval == 0)
                begin
                    dnull = 1'b1;
                end
                else if (!(sgn && dval[63]))
                begin
                    dval = width_trim(dval - 1'b1, wide, sgn);
                end
            end
            present = 1'b1;
        end
        else
        begin
            field_acc      = '0;
            field_bytes    = '0;
            field_negative = 1'b0;
        end

        has_base = dict_valid[slot] || ip;
        base     = dict_valid[slot] ? dict_value[slot] : init;

        // Apply the field operator.
        case (op)
            OP_CONST:
            begin
                r = ((pbit || present) && ip) ? field_word(init, 1'b0, 1'b0, slot)
                                              : field_word('0, 1'b1, 1'b0, slot);
            end
            OP_DFLT:
            begin
                r = present ? field_word(dval, dnull, 1'b0, slot)
                            : field_word(init, !ip, 1'b0, slot);
            end
            OP_COPY, OP_INCR:
            begin
                if (present)
                begin
                    if (!dnull)
                    begin
                        dict_value[slot] = dval;
                        dict_valid[slot] = 1'b1;
                    end
                    r = field_word(dval, dnull, 1'b0, slot);
                end
                else if (!has_base)
                begin
                    r = field_word('0, 1'b1, 1'b0, slot);
                end
                else
                begin
                    if (op == OP_INCR)
                    begin
                        base             = width_trim(base + 1'b1, wide, sgn);
                        dict_value[slot] = base;
                        dict_valid[slot] = 1'b1;
                    end
                    r = field_word(base, 1'b0, 1'b0, slot);
                end
            end
            OP_DIFF:
            begin
                if (!present || (!has_base && dnull))
                begin
                    r = field_word('0, 1'b1, 1'b0, slot);
                end
                else if (dnull)
                begin
                    r = field_word(base, 1'b0, 1'b0, slot);
                end
                else
                begin
                    if (has_base)
                    begin
                        dval = width_trim(base + dval, wide, sgn);
                    end
                    dict_value[slot] = dval;
                    dict_valid[slot] = 1'b1;
                    r = field_word(dval, 1'b0, 1'b0, slot);
                end
            end
            default:
            begin
                r = present ? field_word(dval, dnull, 1'b0, slot)
                            : field_word('0, 1'b1, 1'b0, slot);
            end
        endcase
        expected_fields.push_back(r);
    endtask

    // Watch both channels: compare each delivered word, then predict from each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        field_word_t seen;
        field_word_t want;
        if (!rst_n)
        begin
            field_acc      = '0;
            field_bytes    = '0;
            field_negative = 1'b0;
            for (int i = 0; i < DICT_ENTRIES; i++)
            begin
                dict_value[i] = '0;
                dict_valid[i] = 1'b0;
            end
            expected_fields.delete();
            error_count    = 0;
            mismatch_count = 0;
            checked_count  = 0;
            pending        = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen = field_word_t'(m_tdata);
                if (expected_fields.size() == 0)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: unexpected output word value %h null %b ovl %b slot %0d",
                                 $time, seen.value, seen.is_null, seen.overlong, seen.slot);
                    end
                end
                else
                begin
                    want = expected_fields.pop_front();
                    checked_count++;
                    if (seen.value !== want.value || seen.is_null !== want.is_null ||
                        seen.overlong !== want.overlong || seen.slot !== want.slot)
                    begin
                        error_count++;
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("%0t: mismatch exp value %h null %b ovl %b slot %0d",
                                     $time, want.value, want.is_null, want.overlong, want.slot);
                            $display("%0t:          got value %h null %b ovl %b slot %0d",
                                     $time, seen.value, seen.is_null, seen.overlong, seen.slot);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                decode_word(s_tuser, s_tdata);
            end
            pending = expected_fields.size();
        end
    end

endmodule

FILE: dv/fast_integer_field_decoder_unit_tb.sv
// Testbench top for the FAST integer field decoder: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module fast_integer_field_decoder_unit_tb;
    import fifd_pkg::*;

    // Spare codes the block is expected to ignore or treat as no operator.
    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam int RANDOM_WORDS = 1150;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 20;

    logic                  clk;
    logic                  rst_n;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;

    int error_count;
    int pending;
    int checked_count;
    int words_sent;
    int clears_sent;
    int cycle_count;
    bit steady_phase;

    // Attributes of the field currently being sent.
    logic [7:0]         cur_byte;
    logic [SLOT_W-1:0]  cur_slot;
    logic [2:0]         cur_op;
    logic               cur_pbit;
    logic               cur_sgn;
    logic               cur_wide;
    logic               cur_opt;
    logic [VALUE_W-1:0] cur_init;
    logic               cur_ip;

    fast_integer_field_decoder_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    fifd_stream_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .error_count   (error_count),
        .pending       (pending),
        .checked_count (checked_count)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Timeout.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count, pending);
        $display("DONE: errors detected");
        $finish;
    end

    // Output side: a random stall before each word, none during steady phases.
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = steady_phase ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // Offer one word after a random gap and hold it until the block takes it.
    task automatic send_word(input logic [1:0] act);
        int gap;
        gap = steady_phase ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tuser  <= act;
        s_tdata  <= {2'b00, cur_ip, cur_init, cur_opt, cur_wide, cur_sgn, cur_pbit,
                     cur_op, cur_slot, cur_byte};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (act != ACT_UNUSED)
        begin
            words_sent++;
        end
        if (act == ACT_CLEAR)
        begin
            clears_sent++;
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        cur_byte = b;
        send_word(ACT_DATA);
    endtask

    // Words that carry no byte still get random byte content.
    task automatic send_control(input logic [1:0] act);
        cur_byte = 8'($urandom);
        send_word(act);
    endtask

    task automatic set_field(input logic [SLOT_W-1:0] slot, input logic [2:0] op,
                             input logic sgn, input logic wide, input logic opt,
                             input logic pbit, input logic ip, input logic [VALUE_W-1:0] init);
        cur_slot = slot;
        cur_op   = op;
        cur_sgn  = sgn;
        cur_wide = wide;
        cur_opt  = opt;
        cur_pbit = pbit;
        cur_ip   = ip;
        cur_init = init;
    endtask

    // Random field attributes: mostly a few slots so the dictionary gets reused.
    task automatic pick_attributes();
        cur_slot = SLOT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                       : $urandom_range(0, 7));
        cur_op   = 3'(($urandom_range(0, 19) == 0) ? $urandom_range(6, 7)
                                                   : $urandom_range(0, 5));
        cur_pbit = 1'($urandom_range(0, 1));
        cur_sgn  = 1'($urandom_range(0, 1));
        cur_wide = 1'($urandom_range(0, 1));
        cur_opt  = 1'($urandom_range(0, 1));
        cur_ip   = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       cur_init = 64'h8000_0000_0000_0000;
            1:       cur_init = 64'h7fff_ffff_ffff_ffff;
            2:       cur_init = '1;
            3:       cur_init = '0;
            4:       cur_init = 64'($urandom_range(0, 20));
            default: cur_init = {$urandom, $urandom};
        endcase
    endtask

    // Directed words: byte extremes, every operator, nulls, wrap, overlong and spare codes.
    task automatic run_directed();
        send_control(ACT_CLEAR);
        set_field(6'd0, OP_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        send_byte(8'h80);
        send_byte(8'hff);
        // Signed nullable: zero is null, a negative value is not decremented.
        set_field(6'd1, OP_NONE, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, '0);
        send_byte(8'h80);
        send_byte(8'hff);
        set_field(6'd1, OP_NONE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0);
        send_byte(8'h82);
        send_control(ACT_ABSENT);
        // Constant with and without its presence bit.
        set_field(6'd2, OP_CONST, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 64'h8000_0000_0000_0000);
        send_control(ACT_ABSENT);
        cur_pbit = 1'b0;
        send_control(ACT_ABSENT);
        // Default with and without an initial value.
        set_field(6'd2, OP_DFLT, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 64'h7fff_ffff_ffff_ffff);
        send_control(ACT_ABSENT);
        cur_ip = 1'b0;
        send_control(ACT_ABSENT);
        // Copy stores then repeats.
        set_field(6'd3, OP_COPY, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        send_byte(8'h85);
        send_control(ACT_ABSENT);
        // Increment from an all-ones initial value wraps to zero.
        set_field(6'd4, OP_INCR, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, '1);
        send_control(ACT_ABSENT);
        // Delta with no base, then on top of the stored value, then absent.
        set_field(6'd5, OP_DIFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        send_byte(8'hff);
        send_byte(8'h81);
        send_control(ACT_ABSENT);
        // Narrow field with no stop bit by its fifth byte.
        set_field(6'd6, OP_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        repeat (5) send_byte(8'h00);
        // Spare operators act as none; a spare action is ignored.
        cur_op = OP_SPARE_LO;
        send_byte(8'h81);
        cur_op = OP_SPARE_HI;
        send_control(ACT_ABSENT);
        send_control(ACT_UNUSED);
        // A partial field cut short by an absent word.
        cur_op = OP_NONE;
        send_byte(8'h01);
        send_control(ACT_ABSENT);
    endtask

    // Random field: mostly valid, else absent, clear, spare, overlong, cut short or noisy.
    task automatic random_field();
        int kind;
        int len;
        int limit;
        kind = $urandom_range(0, 99);
        pick_attributes();
        limit = cur_wide ? MAX_BYTES_WIDE : MAX_BYTES_NARROW;
        if (kind < 70)
        begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, limit) : $urandom_range(1, 2);
            for (int i = 1; i <= len; i++)
            begin
                send_byte({i == len, 7'($urandom)});
            end
        end
        else if (kind < 85)
        begin
            send_control(ACT_ABSENT);
        end
        else if (kind < 87)
        begin
            send_control(ACT_CLEAR);
        end
        else if (kind < 89)
        begin
            send_control(ACT_UNUSED);
        end
        else if (kind < 93)
        begin
            repeat (limit) send_byte({1'b0, 7'($urandom)});
        end
        else if (kind < 97)
        begin
            repeat ($urandom_range(1, limit - 1)) send_byte({1'b0, 7'($urandom)});
            send_control($urandom_range(0, 1) ? ACT_ABSENT : ACT_CLEAR);
        end
        else
        begin
            // Attributes change between the first and the stop byte.
            send_byte({1'b0, 7'($urandom)});
            pick_attributes();
            send_byte({1'b1, 7'($urandom)});
        end
    endtask

    // Main sequence.
    initial
    begin
        int next_phase;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= ACT_DATA;
        rst_n        <= 1'b0;
        words_sent   = 0;
        clears_sent  = 0;
        steady_phase = 1'b0;
        set_field('0, OP_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        cur_byte = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        run_directed();

        // Random part, switching between idling and steady phases now and then.
        next_phase = words_sent + 64;
        while (words_sent < RANDOM_WORDS + 25)
        begin
            if (words_sent >= next_phase)
            begin
                steady_phase = ($urandom_range(0, 3) == 0);
                next_phase   = words_sent + 64;
            end
            random_field();
        end
        s_tvalid <= 1'b0;

        // Drain the expected results, then allow for the pipeline latency.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d input words (%0d dictionary clears) over %0d cycles.",
                 words_sent, clears_sent, cycle_count);
        $display("Checked %0d decoded fields across all operators and field kinds.",
                 checked_count);
        if (error_count == 0 && pending == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
